// ----- rtl/ght_pkg.sv -----
// Package for the generational handle table: types, codes and constants.
// Used by every module of the block but ght_ram; depends on nothing.
package ght_pkg;

  // Default table size and fixed field widths.
  localparam int NumSlotsDef = 64;
  localparam int HandleW     = 32;
  localparam int GenW        = 16;
  localparam int SlotFieldW  = 16;
  localparam int IdW         = 16;
  localparam int AddrW       = 64;
  localparam int WeightW     = 14;
  localparam int SliceW      = 32;
  localparam int DefSliceW   = 16;
  localparam int ValueW      = 32;
  localparam int LiveW       = 7;
  localparam int CmdW        = 3;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 16;

  localparam logic [WeightW-1:0]   WeightMax      = 14'd10240;
  localparam logic [WeightW-1:0]   BaseWeightRst  = 14'd1024;
  localparam logic [DefSliceW-1:0] DefaultSliceRst = 16'd4;
  localparam logic [GenW-1:0]      GenFirst       = 16'd1;

  typedef enum logic [CmdW-1:0] {
    CMD_CREATE    = 3'd0,
    CMD_LOOKUP    = 3'd1,
    CMD_TERMINATE = 3'd2,
    CMD_SET_WEIGHT = 3'd3,
    CMD_SET_SLICE = 3'd4,
    CMD_SET_CUR   = 3'd5,
    CMD_CLEAR_CUR = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_BAD  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    SLOT_UNUSED = 2'd0,
    SLOT_READY  = 2'd1,
    SLOT_TERM   = 2'd2
  } slot_st_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BASE_WEIGHT   = 2'd0,
    CFG_DEFAULT_SLICE = 2'd1
  } cfg_idx_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  // One slot record as held in the record memory.
  typedef struct packed {
    logic [GenW-1:0]    gen;
    logic [IdW-1:0]     service;
    logic [IdW-1:0]     domain;
    logic [AddrW-1:0]   start_addr;
    logic [AddrW-1:0]   stack_ptr;
    logic [WeightW-1:0] weight;
    logic [SliceW-1:0]  slice;
  } slot_rec_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
  } ght_ctl_t;

  // Weight is held to 1..WeightMax.
  function automatic logic [WeightW-1:0] clamp_weight(input logic [ValueW-1:0] w);
    logic [WeightW-1:0] r;
    if (w == '0) begin
      r = WeightW'(1);
    end else if (w > ValueW'(WeightMax)) begin
      r = WeightMax;
    end else begin
      r = w[WeightW-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/generational_handle_table.sv -----
// Generational handle table. A command taken at a clock edge with start high and
// busy low gives its result, marked by done_o, once the execute cycle has loaded
// the result registers. The slot record is read in the start cycle and written
// back in the execute cycle, through the single record RAM port pair, and busy
// is high in that cycle. Reset is asynchronous and needs no clearing pass;
// results cannot be stalled. Depends on ght_pkg, ght_ctrl, ght_dp and ght_ram.
module generational_handle_table #(
  parameter int NUM_SLOTS = ght_pkg::NumSlotsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Command channel.
  input  logic                         start,
  output logic                         busy,
  input  logic [ght_pkg::CmdW-1:0]     cmd_i,
  input  logic [ght_pkg::HandleW-1:0]  handle_i,
  input  logic [ght_pkg::IdW-1:0]      service_id_i,
  input  logic [ght_pkg::IdW-1:0]      domain_id_i,
  input  logic [ght_pkg::AddrW-1:0]    start_addr_i,
  input  logic [ght_pkg::AddrW-1:0]    stack_ptr_i,
  input  logic [ght_pkg::ValueW-1:0]   value_i,
  // Configuration write channel.
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ght_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ght_pkg::CfgDataW-1:0] cfg_data_i,
  // Result channel.
  output logic                         done_o,
  output logic [1:0]                   status_o,
  output logic [ght_pkg::HandleW-1:0]  result_handle_o,
  output logic [ght_pkg::IdW-1:0]      out_service_id_o,
  output logic [ght_pkg::IdW-1:0]      out_domain_id_o,
  output logic [ght_pkg::AddrW-1:0]    out_start_addr_o,
  output logic [ght_pkg::AddrW-1:0]    out_stack_ptr_o,
  output logic [ght_pkg::WeightW-1:0]  out_weight_o,
  output logic [ght_pkg::SliceW-1:0]   out_slice_o,
  output logic [ght_pkg::LiveW-1:0]    live_count_o,
  output logic                         is_current_o
);

  // The live count reported when every slot is taken, modulo the port width.
  localparam logic [ght_pkg::LiveW-1:0] FullCount = ght_pkg::LiveW'(NUM_SLOTS);

  ght_pkg::ght_ctl_t ctl;

  // Configuration writes are always taken: the user must keep the block idle.
  assign cfg_ready_o = 1'b1;

  // The controller sequences each transaction: capture with the record read,
  // then an execute cycle that updates the slot and loads the result registers.
  ght_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .ctl_o  (ctl)
  );

  // The datapath holds the slot states in flops, so the lowest free slot is
  // found in the start cycle, and the records in a RAM. An unused slot always
  // reads as generation one, which stands in for clearing the RAM at reset.
  ght_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctl_i            (ctl),
    .cfg_we_i         (cfg_valid_i & cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .cmd_i            (cmd_i),
    .handle_i         (handle_i),
    .service_id_i     (service_id_i),
    .domain_id_i      (domain_id_i),
    .start_addr_i     (start_addr_i),
    .stack_ptr_i      (stack_ptr_i),
    .value_i          (value_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .result_handle_o  (result_handle_o),
    .out_service_id_o (out_service_id_o),
    .out_domain_id_o  (out_domain_id_o),
    .out_start_addr_o (out_start_addr_o),
    .out_stack_ptr_o  (out_stack_ptr_o),
    .out_weight_o     (out_weight_o),
    .out_slice_o      (out_slice_o),
    .live_count_o     (live_count_o),
    .is_current_o     (is_current_o)
  );

  // Every execute cycle is followed by exactly one result strobe.
  a_exec_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> done_o && !busy)
    else $error("result strobe did not follow the execute cycle");

  // The live count moves only as a transaction finishes.
  a_live_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(busy) |-> $stable(live_count_o))
    else $error("live count changed outside a transaction");

  // A full table means every slot holds a live task.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == ght_pkg::STAT_FULL |-> live_count_o == FullCount)
    else $error("table full reported with a free slot");

  // A failed transaction reports no slot contents.
  a_fail_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != ght_pkg::STAT_OK |-> out_weight_o == '0 && !is_current_o)
    else $error("slot fields reported on a failed transaction");

endmodule

// ----- rtl/ght_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Stands alone; used for the slot record store.
module ght_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/ght_ctrl.sv -----
// Controller of the generational handle table: a two-state sequencer.
// Depends on ght_pkg for the state and control types.
module ght_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output ght_pkg::ght_ctl_t ctl_o
);

  ght_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ght_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ctl_o       = '0;
    busy        = 1'b0;
    case (state_q)
      ght_pkg::ST_IDLE: begin
        // The record read is issued in the same cycle the command is taken.
        if (start) begin
          ctl_o.capture = 1'b1;
          state_d       = ght_pkg::ST_EXEC;
        end
      end
      ght_pkg::ST_EXEC: begin
        busy       = 1'b1;
        ctl_o.exec = 1'b1;
        state_d    = ght_pkg::ST_IDLE;
      end
      default: begin
        state_d = ght_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/ght_dp.sv -----
// Datapath of the generational handle table: slot state flops, record RAM,
// free-slot search, command execution and result registers. Uses ght_pkg, ght_ram.
module ght_dp #(
  parameter int NUM_SLOTS = ght_pkg::NumSlotsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ght_pkg::ght_ctl_t                   ctl_i,
  input  logic                                cfg_we_i,
  input  logic [ght_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [ght_pkg::CfgDataW-1:0]        cfg_data_i,
  input  logic [ght_pkg::CmdW-1:0]            cmd_i,
  input  logic [ght_pkg::HandleW-1:0]         handle_i,
  input  logic [ght_pkg::IdW-1:0]             service_id_i,
  input  logic [ght_pkg::IdW-1:0]             domain_id_i,
  input  logic [ght_pkg::AddrW-1:0]           start_addr_i,
  input  logic [ght_pkg::AddrW-1:0]           stack_ptr_i,
  input  logic [ght_pkg::ValueW-1:0]          value_i,
  output logic                                done_o,
  output logic [1:0]                          status_o,
  output logic [ght_pkg::HandleW-1:0]         result_handle_o,
  output logic [ght_pkg::IdW-1:0]             out_service_id_o,
  output logic [ght_pkg::IdW-1:0]             out_domain_id_o,
  output logic [ght_pkg::AddrW-1:0]           out_start_addr_o,
  output logic [ght_pkg::AddrW-1:0]           out_stack_ptr_o,
  output logic [ght_pkg::WeightW-1:0]         out_weight_o,
  output logic [ght_pkg::SliceW-1:0]          out_slice_o,
  output logic [ght_pkg::LiveW-1:0]           live_count_o,
  output logic                                is_current_o
);

  localparam int IdxW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int RangeW = ght_pkg::SlotFieldW + 1;
  localparam int RecW   = $bits(ght_pkg::slot_rec_t);

  // Control state.
  ght_pkg::slot_st_e                 slot_st_q [NUM_SLOTS];
  logic [ght_pkg::LiveW-1:0]         live_q, live_d;
  logic                              cur_v_q, cur_v_d;
  logic [IdxW-1:0]                   cur_s_q, cur_s_d;
  logic [ght_pkg::WeightW-1:0]       base_weight_q;
  logic [ght_pkg::DefSliceW-1:0]     def_slice_q;
  logic                              done_q;

  // Captured command.
  logic [ght_pkg::CmdW-1:0]          cmd_q;
  logic [ght_pkg::HandleW-1:0]       handle_q;
  logic [ght_pkg::IdW-1:0]           service_q, domain_q;
  logic [ght_pkg::AddrW-1:0]         start_addr_q, stack_ptr_q;
  logic [ght_pkg::ValueW-1:0]        value_q;
  logic [IdxW-1:0]                   sel_q;
  logic                              in_range_q, found_q;

  // Free-slot search and read address.
  logic [IdxW-1:0]                   free_idx;
  logic                              free_found;
  logic [IdxW-1:0]                   rd_idx;
  logic                              in_range;

  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (slot_st_q[i] != ght_pkg::SLOT_READY) begin
        free_idx   = IdxW'(i);
        free_found = 1'b1;
      end
    end
  end

  assign in_range = {1'b0, handle_i[ght_pkg::SlotFieldW-1:0]} < RangeW'(NUM_SLOTS);
  assign rd_idx   = (ght_pkg::cmd_e'(cmd_i) == ght_pkg::CMD_CREATE) ? free_idx
                                                                     : handle_i[IdxW-1:0];

  // Record store.
  logic [RecW-1:0]     rdata;
  ght_pkg::slot_rec_t  rec_rd, rec_new;
  logic                rec_we;

  ght_ram #(
    .Width (RecW),
    .Depth (NUM_SLOTS)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.exec & rec_we),
    .waddr_i (sel_q),
    .wdata_i (rec_new),
    .re_i    (ctl_i.capture),
    .raddr_i (rd_idx),
    .rdata_o (rdata)
  );

  assign rec_rd = ght_pkg::slot_rec_t'(rdata);

  // Command execution.
  ght_pkg::slot_st_e           st_cur, st_new;
  logic                        st_we;
  logic [ght_pkg::GenW-1:0]    gen_cur, gen_next;
  logic                        handle_ok;
  ght_pkg::status_e            o_status;
  logic [ght_pkg::HandleW-1:0] o_handle;
  logic                        emit;

  always_comb begin
    st_cur    = slot_st_q[sel_q];
    // A slot that was never used still carries its first generation.
    gen_cur   = (st_cur == ght_pkg::SLOT_UNUSED) ? ght_pkg::GenFirst : rec_rd.gen;
    handle_ok = in_range_q && (st_cur != ght_pkg::SLOT_UNUSED) &&
                (rec_rd.gen == handle_q[ght_pkg::HandleW-1:ght_pkg::SlotFieldW]);
    gen_next  = rec_rd.gen + ght_pkg::GenW'(1);
    if (gen_next == '0) begin
      gen_next = ght_pkg::GenFirst;
    end
    rec_new   = rec_rd;
    rec_we    = 1'b0;
    st_new    = st_cur;
    st_we     = 1'b0;
    live_d    = live_q;
    cur_v_d   = cur_v_q;
    cur_s_d   = cur_s_q;
    o_status  = ght_pkg::STAT_OK;
    o_handle  = handle_q;
    emit      = 1'b0;
    case (ght_pkg::cmd_e'(cmd_q))
      ght_pkg::CMD_CREATE: begin
        if (!found_q) begin
          o_status = ght_pkg::STAT_FULL;
          o_handle = '0;
        end else begin
          rec_new.gen        = (gen_cur == '0) ? ght_pkg::GenFirst : gen_cur;
          rec_new.service    = service_q;
          rec_new.domain     = domain_q;
          rec_new.start_addr = start_addr_q;
          rec_new.stack_ptr  = stack_ptr_q;
          rec_new.weight     = ght_pkg::clamp_weight(ght_pkg::ValueW'(base_weight_q));
          rec_new.slice      = (def_slice_q == '0) ? ght_pkg::SliceW'(1)
                                                   : ght_pkg::SliceW'(def_slice_q);
          rec_we   = 1'b1;
          st_new   = ght_pkg::SLOT_READY;
          st_we    = 1'b1;
          live_d   = live_q + ght_pkg::LiveW'(1);
          o_handle = {rec_new.gen, ght_pkg::SlotFieldW'(sel_q)};
          emit     = 1'b1;
        end
      end
      ght_pkg::CMD_CLEAR_CUR: begin
        cur_v_d = 1'b0;
        cur_s_d = '0;
      end
      default: begin
        if (!handle_ok) begin
          o_status = ght_pkg::STAT_BAD;
        end else begin
          emit = 1'b1;
          case (ght_pkg::cmd_e'(cmd_q))
            ght_pkg::CMD_LOOKUP: begin
            end
            ght_pkg::CMD_TERMINATE: begin
              // A ready slot is always part of the count, so the count wraps
              // with the port width just as it does on create.
              if (st_cur == ght_pkg::SLOT_READY) begin
                live_d = live_q - ght_pkg::LiveW'(1);
              end
              st_new      = ght_pkg::SLOT_TERM;
              st_we       = 1'b1;
              rec_new.gen = gen_next;
              rec_we      = 1'b1;
              if (cur_v_q && cur_s_q == sel_q) begin
                cur_v_d = 1'b0;
                cur_s_d = '0;
              end
            end
            ght_pkg::CMD_SET_WEIGHT: begin
              rec_new.weight = ght_pkg::clamp_weight(value_q);
              rec_we         = 1'b1;
            end
            ght_pkg::CMD_SET_SLICE: begin
              rec_new.slice = (value_q == '0) ? ght_pkg::SliceW'(1) : value_q;
              rec_we        = 1'b1;
            end
            ght_pkg::CMD_SET_CUR: begin
              cur_v_d = 1'b1;
              cur_s_d = sel_q;
            end
            default: begin
              // Undefined command code.
              o_status = ght_pkg::STAT_BAD;
              emit     = 1'b0;
            end
          endcase
        end
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_st_q[i] <= ght_pkg::SLOT_UNUSED;
      end
      live_q        <= '0;
      cur_v_q       <= 1'b0;
      cur_s_q       <= '0;
      base_weight_q <= ght_pkg::BaseWeightRst;
      def_slice_q   <= ght_pkg::DefaultSliceRst;
      done_q        <= 1'b0;
    end else begin
      done_q <= ctl_i.exec;
      if (ctl_i.exec) begin
        if (st_we) begin
          slot_st_q[sel_q] <= st_new;
        end
        live_q  <= live_d;
        cur_v_q <= cur_v_d;
        cur_s_q <= cur_s_d;
      end
      if (cfg_we_i) begin
        case (ght_pkg::cfg_idx_e'(cfg_index_i))
          ght_pkg::CFG_BASE_WEIGHT:   base_weight_q <= cfg_data_i[ght_pkg::WeightW-1:0];
          ght_pkg::CFG_DEFAULT_SLICE: def_slice_q   <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  // Command capture and result registers.
  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cmd_q        <= cmd_i;
      handle_q     <= handle_i;
      service_q    <= service_id_i;
      domain_q     <= domain_id_i;
      start_addr_q <= start_addr_i;
      stack_ptr_q  <= stack_ptr_i;
      value_q      <= value_i;
      sel_q        <= rd_idx;
      in_range_q   <= in_range;
      found_q      <= free_found;
    end
    if (ctl_i.exec) begin
      status_o         <= o_status;
      result_handle_o  <= o_handle;
      out_service_id_o <= emit ? rec_new.service    : '0;
      out_domain_id_o  <= emit ? rec_new.domain     : '0;
      out_start_addr_o <= emit ? rec_new.start_addr : '0;
      out_stack_ptr_o  <= emit ? rec_new.stack_ptr  : '0;
      out_weight_o     <= emit ? rec_new.weight     : '0;
      out_slice_o      <= emit ? rec_new.slice      : '0;
      is_current_o     <= emit && cur_v_d && (cur_s_d == sel_q);
    end
  end

  assign done_o       = done_q;
  assign live_count_o = live_q;

endmodule
